@@ design/jcfs_pkg.sv @@
// jcfs_pkg: shared types and constants for the jacobi channel flow solver
`timescale 1ns / 1ps
package jcfs_pkg;

  localparam int MAX_NODES = 32;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int CHG_W     = 32 + $clog2(MAX_NODES);

  localparam logic [15:0] SWEEP_CAP = 16'd65535;

  localparam logic [7:0] REG_NODE_COUNT = 8'd0;
  localparam logic [7:0] REG_TOLERANCE  = 8'd1;

  typedef struct packed {
    logic signed [31:0] source_term;
    logic signed [31:0] wall_velocity;
  } in_t;

  typedef struct packed {
    logic [5:0]         node_index;
    logic signed [31:0] velocity;
    logic [15:0]        sweeps_done;
    logic               converged;
    logic               last;
  } out_t;

  typedef struct packed {
    logic load;
    logic sweep;
    logic shift_diff;
    logic shift_vel;
  } cell_ctl_t;

endpackage

@@ design/jacobi_channel_flow_solver.sv @@
// jacobi_channel_flow_solver: top level, control sequencer and row of node cells
`timescale 1ns / 1ps
// Usage: write node_count (index 0) and tolerance (index 1) on the cfg channel
// while the block is idle; cfg_ready is always high. Pulse start with an item
// on req while busy is low. The profile is cleared, the top wall loaded, and
// Jacobi sweeps run on a row of 32 node cells: every interior cell relaxes at
// once, then the per-cell changes shift down the row into one adder and the
// total is checked against the tolerance. Sweeps stop when the change is at
// or below tolerance or after 65535 sweeps.
// Then one result per node, bottom wall first, appears on result with strobe
// high for one cycle each, on consecutive cycles; last marks the top wall.
// busy is high from the first sweep through the last result, and the next
// item is taken the cycle after the last result.
// The receiver cannot stall; results are not held. Reset (rst, synchronous)
// returns to idle with node_count 32 and tolerance 1.
module jacobi_channel_flow_solver (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  jcfs_pkg::in_t   req,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output logic            strobe,
  output jcfs_pkg::out_t  result
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SWEEP  = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  localparam int N = jcfs_pkg::MAX_NODES;

  logic [2:0]                    state;
  logic [6:0]                    node_count;
  logic [31:0]                   tolerance;
  logic [jcfs_pkg::CNT_W-1:0]    n_use;
  logic [jcfs_pkg::CNT_W-1:0]    n_clamp;
  logic signed [31:0]            src;
  logic [15:0]                   sweeps;
  logic                          conv;
  logic                          meets_tol;
  logic [jcfs_pkg::IDX_W-1:0]    cnt;
  logic [jcfs_pkg::CHG_W-1:0]    acc;
  logic                          accept;
  jcfs_pkg::cell_ctl_t           ctl;

  logic signed [31:0] vel  [N];
  logic [31:0]        diff [N];

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign meets_tol = (acc <= jcfs_pkg::CHG_W'(tolerance));

  always_comb begin
    if (node_count < 7'd3) begin
      n_clamp = jcfs_pkg::CNT_W'(3);
    end else if (node_count > 7'(N)) begin
      n_clamp = jcfs_pkg::CNT_W'(N);
    end else begin
      n_clamp = node_count[jcfs_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    ctl.load       = accept;
    ctl.sweep      = (state == ST_SWEEP);
    ctl.shift_diff = (state == ST_SUM);
    ctl.shift_vel  = (state == ST_OUT);
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [jcfs_pkg::CNT_W-1:0] POS = jcfs_pkg::CNT_W'(i);
    logic               interior;
    logic               is_top;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [31:0]        diff_in;

    assign interior = (i != 0) && (POS + 1'b1 < n_use);
    assign is_top   = (POS + 1'b1 == n_clamp);
    assign lo       = (i == 0) ? 32'sd0 : vel[(i == 0) ? 0 : i - 1];
    assign hi       = (i == N - 1) ? 32'sd0 : vel[(i == N - 1) ? i : i + 1];
    assign diff_in  = (i == N - 1) ? 32'd0 : diff[(i == N - 1) ? i : i + 1];

    jcfs_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .interior (interior),
      .is_top   (is_top),
      .wall     (req.wall_velocity),
      .src      (src),
      .lo       (lo),
      .hi       (hi),
      .diff_in  (diff_in),
      .vel      (vel[i]),
      .diff     (diff[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= 7'd32;
      tolerance  <= 32'd1;
      cnt        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == jcfs_pkg::REG_NODE_COUNT) begin
          node_count <= cfg_data[6:0];
        end else if (cfg_index == jcfs_pkg::REG_TOLERANCE) begin
          tolerance <= cfg_data;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          cnt   <= '0;
          state <= ST_SUM;
        end
        ST_SUM: begin
          cnt <= cnt + 1'b1;
          if (cnt == jcfs_pkg::IDX_W'(N - 1)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          cnt <= '0;
          if (meets_tol || sweeps >= jcfs_pkg::SWEEP_CAP) begin
            state <= ST_OUT;
          end else begin
            state <= ST_SWEEP;
          end
        end
        ST_OUT: begin
          cnt <= cnt + 1'b1;
          if (jcfs_pkg::CNT_W'(cnt) + 1'b1 == n_use) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item payload and running solve figures
  always_ff @(posedge clk) begin
    if (accept) begin
      src    <= req.source_term;
      n_use  <= n_clamp;
      sweeps <= 16'd0;
    end
    if (state == ST_SWEEP) begin
      sweeps <= sweeps + 16'd1;
      acc    <= '0;
    end
    if (state == ST_SUM) begin
      acc <= acc + jcfs_pkg::CHG_W'(diff[0]);
    end
    if (state == ST_DECIDE) begin
      conv <= meets_tol;
    end
  end

  always_comb begin
    strobe             = (state == ST_OUT);
    result.node_index  = 6'(cnt);
    result.velocity    = vel[0];
    result.sweeps_done = sweeps;
    result.converged   = conv;
    result.last        = (jcfs_pkg::CNT_W'(cnt) + 1'b1 == n_use);
  end

endmodule

@@ design/jcfs_cell.sv @@
// jcfs_cell: one grid node, holds its velocity and last change, talks to its neighbors
`timescale 1ns / 1ps
module jcfs_cell (
  input  logic               clk,
  input  jcfs_pkg::cell_ctl_t ctl,
  input  logic               interior,
  input  logic               is_top,
  input  logic signed [31:0] wall,
  input  logic signed [31:0] src,
  input  logic signed [31:0] lo,
  input  logic signed [31:0] hi,
  input  logic [31:0]        diff_in,
  output logic signed [31:0] vel,
  output logic [31:0]        diff
);

  logic signed [33:0] sum;
  logic signed [32:0] half;
  logic signed [31:0] relaxed;
  logic signed [32:0] delta;
  logic [32:0]        mag;

  always_comb begin
    sum  = 34'(lo) + 34'(hi) + 34'(src);
    half = sum[33:1];
    // saturate the floored half back into 32 bits
    if (half[32] != half[31]) begin
      relaxed = half[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      relaxed = half[31:0];
    end
    delta = 33'(vel) - 33'(relaxed);
    mag   = delta[32] ? 33'(-delta) : 33'(delta);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      vel  <= is_top ? wall : 32'sd0;
      diff <= 32'd0;
    end else if (ctl.sweep) begin
      if (interior) begin
        vel  <= relaxed;
        diff <= mag[31:0];
      end else begin
        diff <= 32'd0;
      end
    end else if (ctl.shift_diff) begin
      diff <= diff_in;
    end else if (ctl.shift_vel) begin
      vel <= hi;
    end
  end

endmodule
